FILE: hdl/plb_pkg.sv
// Shared types and constants for the price-level order book.
// Level and request structs, command and side codes.
// No dependencies.
`timescale 1ns / 1ps

package plb_pkg;

  localparam int LEVELS     = 64;
  localparam int VALUE_BITS = 48;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_BID   = 2'd0,
    CMD_ASK   = 2'd1,
    CMD_TRADE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_BUY     = 2'd1,
    SIDE_SELL    = 2'd2,
    SIDE_BAD     = 2'd3
  } side_t;

  typedef struct packed {
    logic   valid;
    value_t price;
    value_t amount;
  } level_t;

  typedef struct packed {
    logic   desc;
    value_t price;
    value_t amount;
  } req_t;

  typedef struct packed {
    logic upd;
    logic del;
    logic ins;
  } op_t;

  typedef struct packed {
    logic   top;
    logic   ovf;
    level_t head;
  } row_stat_t;

endpackage

FILE: hdl/plb_in_if.sv
// Request channel of the price-level order book.
// Valid/ready handshake with command, price, amount and side; uses plb_pkg.
`timescale 1ns / 1ps

interface plb_in_if import plb_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  value_t     price;
  value_t     amount;
  logic [1:0] side;

  modport source (output valid, cmd, price, amount, side, input ready);
  modport sink   (input valid, cmd, price, amount, side, output ready);
endinterface

FILE: hdl/plb_out_if.sv
// Result channel of the price-level order book.
// Valid/ready handshake with top of book and last trade; uses plb_pkg.
`timescale 1ns / 1ps

interface plb_out_if import plb_pkg::*;;
  logic       valid;
  logic       ready;
  logic       top_changed;
  value_t     best_bid_price;
  value_t     best_bid_amount;
  logic       bid_valid;
  value_t     best_ask_price;
  value_t     best_ask_amount;
  logic       ask_valid;
  value_t     trade_price;
  value_t     trade_amount;
  logic [1:0] trade_side;
  logic       overflow;

  modport source (output valid, top_changed, best_bid_price, best_bid_amount, bid_valid,
                  best_ask_price, best_ask_amount, ask_valid, trade_price, trade_amount,
                  trade_side, overflow, input ready);
  modport sink   (input valid, top_changed, best_bid_price, best_bid_amount, bid_valid,
                  best_ask_price, best_ask_amount, ask_valid, trade_price, trade_amount,
                  trade_side, overflow, output ready);
endinterface

FILE: hdl/plb_cell.sv
// One slot of a sorted price table: compares the broadcast price and takes
// its own, left or right neighbor's, or the request's level. Uses plb_pkg.
`timescale 1ns / 1ps

module plb_cell import plb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  req_t   req,
  input  op_t    op,
  input  level_t left_lvl,
  input  logic   left_ins,
  input  level_t right_lvl,
  output level_t cur,
  output level_t nxt,
  output logic   match,
  output logic   ins
);

  logic   vld_r;
  value_t price_r;
  value_t amount_r;
  logic   better;
  logic   ge;

  assign cur    = '{valid: vld_r, price: price_r, amount: amount_r};
  assign better = vld_r && (req.desc ? (req.price > price_r) : (req.price < price_r));
  assign match  = vld_r && (req.price == price_r);
  assign ge     = match || better;
  assign ins    = !vld_r || better;

  always_comb begin
    nxt = cur;
    if (op.upd && match) begin
      nxt.amount = req.amount;
    end
    if (op.del && ge) begin
      nxt = right_lvl;
    end
    if (op.ins && ins) begin
      if (left_ins) begin
        nxt = left_lvl;
      end else begin
        nxt = '{valid: 1'b1, price: req.price, amount: req.amount};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    price_r  <= nxt.price;
    amount_r <= nxt.amount;
  end

endmodule

FILE: hdl/plb_row.sv
// Sorted price table built as a row of plb_cell slots; decodes replace,
// remove and insert from the per-cell flags. Uses plb_pkg and plb_cell.
`timescale 1ns / 1ps

module plb_row import plb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      desc,
  input  value_t    price,
  input  value_t    amount,
  output row_stat_t stat
);

  req_t              req;
  op_t               op;
  level_t            cur_arr  [LEVELS+1];
  level_t            nxt_arr  [LEVELS];
  level_t            left_arr [LEVELS];
  logic [LEVELS-1:0] match_vec;
  logic [LEVELS-1:0] ins_vec;
  logic [LEVELS-1:0] vld_vec;
  logic [LEVELS:0]   ins_ext;
  logic              any_match;
  logic              amt_zero;

  assign req       = '{desc: desc, price: price, amount: amount};
  assign any_match = |match_vec;
  assign amt_zero  = (amount == '0);
  assign ins_ext   = {ins_vec, 1'b0};
  assign cur_arr[LEVELS] = '0;

  assign op.upd = en && any_match && !amt_zero;
  assign op.del = en && any_match && amt_zero;
  assign op.ins = en && !any_match && !amt_zero;

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign left_arr[k] = '0;
    end else begin : g_body
      assign left_arr[k] = cur_arr[k-1];
    end
    assign vld_vec[k] = cur_arr[k].valid;

    plb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .op        (op),
      .left_lvl  (left_arr[k]),
      .left_ins  (ins_ext[k]),
      .right_lvl (cur_arr[k+1]),
      .cur       (cur_arr[k]),
      .nxt       (nxt_arr[k]),
      .match     (match_vec[k]),
      .ins       (ins_vec[k])
    );
  end

  assign stat.top  = en && (any_match ? match_vec[0] : (!amt_zero && ins_vec[0]));
  assign stat.ovf  = op.ins && vld_vec[LEVELS-1];
  assign stat.head = nxt_arr[0];

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("table valid flags are not contiguous");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("price held by more than one level");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ovf |=> vld_vec[LEVELS-1])
    else $error("table not full after overflow");

  a_del: assert property (@(posedge clk) disable iff (!rst_n)
    op.del |=> ($countones(vld_vec) + 1 == $countones($past(vld_vec))))
    else $error("remove did not drop exactly one level");

  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    (op.ins && !vld_vec[LEVELS-1]) |=>
      ($countones(vld_vec) == $countones($past(vld_vec)) + 1))
    else $error("insert did not add exactly one level");

endmodule

FILE: hdl/price_level_order_book.sv
// Price-level order book top level: bid and ask tables plus last trade.
// Uses plb_pkg, plb_in_if, plb_out_if and plb_row.
//
// Usage:
//   in_ch  : request channel (valid/ready). cmd 0 updates a bid level, 1 an
//            ask level, 2 records a trade; cmd 3 is ignored. An amount of
//            zero removes the level at that price.
//   out_ch : one result per request, in order: top_changed, best bid and
//            ask with valid flags, last trade and the overflow flag.
// Each table is a row of LEVELS cells, one level per cell; every cell
// compares the request price at once and shifts toward its neighbor, so
// the whole table is updated at once when a request is taken.
// The result is registered, shown in the cycle after the request is taken.
// Throughput: one request per cycle while out_ch.ready stays high.
// A single output register holds the result; when out_ch stalls, in_ch.ready
// drops until the held result is taken, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both tables, clears the last trade
// to zero with side unknown and drops any pending result. No clearing pass
// is needed; requests are taken from the first cycle after reset.
`timescale 1ns / 1ps

module price_level_order_book import plb_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  plb_in_if.sink        in_ch,
  plb_out_if.source     out_ch
);

  logic       acc;
  logic       bid_en;
  logic       ask_en;
  logic       trd_en;
  row_stat_t  bid_stat;
  row_stat_t  ask_stat;
  side_t      side_in;

  value_t     last_price_r;
  value_t     last_amount_r;
  logic [1:0] last_side_r;
  value_t     last_price_nxt;
  value_t     last_amount_nxt;
  logic [1:0] last_side_nxt;

  logic       out_vld_r;
  logic       top_r;
  value_t     bid_price_r;
  value_t     bid_amount_r;
  logic       bid_vld_r;
  value_t     ask_price_r;
  value_t     ask_amount_r;
  logic       ask_vld_r;
  logic       ovf_r;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign side_in     = side_t'(in_ch.side);

  always_comb begin
    bid_en = 1'b0;
    ask_en = 1'b0;
    trd_en = 1'b0;
    case (cmd_t'(in_ch.cmd))
      CMD_BID:   bid_en = acc;
      CMD_ASK:   ask_en = acc;
      CMD_TRADE: trd_en = acc;
      default:   ;
    endcase
  end

  plb_row u_bid (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (bid_en),
    .desc   (1'b1),
    .price  (in_ch.price),
    .amount (in_ch.amount),
    .stat   (bid_stat)
  );

  plb_row u_ask (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (ask_en),
    .desc   (1'b0),
    .price  (in_ch.price),
    .amount (in_ch.amount),
    .stat   (ask_stat)
  );

  always_comb begin
    last_price_nxt  = last_price_r;
    last_amount_nxt = last_amount_r;
    last_side_nxt   = last_side_r;
    if (trd_en) begin
      last_price_nxt  = in_ch.price;
      last_amount_nxt = in_ch.amount;
      case (side_in)
        SIDE_UNKNOWN: last_side_nxt = SIDE_UNKNOWN;
        SIDE_BUY:     last_side_nxt = SIDE_BUY;
        SIDE_SELL:    last_side_nxt = SIDE_SELL;
        default:      last_side_nxt = SIDE_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_price_r  <= '0;
      last_amount_r <= '0;
      last_side_r   <= SIDE_UNKNOWN;
      out_vld_r     <= 1'b0;
    end else begin
      last_price_r  <= last_price_nxt;
      last_amount_r <= last_amount_nxt;
      last_side_r   <= last_side_nxt;
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      top_r        <= bid_stat.top || ask_stat.top;
      ovf_r        <= bid_stat.ovf || ask_stat.ovf;
      bid_vld_r    <= bid_stat.head.valid;
      bid_price_r  <= bid_stat.head.valid ? bid_stat.head.price : '0;
      bid_amount_r <= bid_stat.head.valid ? bid_stat.head.amount : '0;
      ask_vld_r    <= ask_stat.head.valid;
      ask_price_r  <= ask_stat.head.valid ? ask_stat.head.price : '0;
      ask_amount_r <= ask_stat.head.valid ? ask_stat.head.amount : '0;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.top_changed     = top_r;
  assign out_ch.best_bid_price  = bid_price_r;
  assign out_ch.best_bid_amount = bid_amount_r;
  assign out_ch.bid_valid       = bid_vld_r;
  assign out_ch.best_ask_price  = ask_price_r;
  assign out_ch.best_ask_amount = ask_amount_r;
  assign out_ch.ask_valid       = ask_vld_r;
  assign out_ch.trade_price     = last_price_r;
  assign out_ch.trade_amount    = last_amount_r;
  assign out_ch.trade_side      = last_side_r;
  assign out_ch.overflow        = ovf_r;

endmodule

FILE: verif/price_level_order_book_tb.sv
// Testbench for the price-level order book: directed and random level updates and trades.
// Predicts the full result after each request and checks every result in order.
// Depends on plb_pkg, plb_in_if, plb_out_if and price_level_order_book.
`timescale 1ns / 1ps

module price_level_order_book_tb;
  import plb_pkg::*;

  localparam int     BID_BOOK     = 0;
  localparam int     ASK_BOOK     = 1;
  localparam int     POOL_SPAN    = 120;
  localparam int     LIMIT_CYCLES = 500000;
  localparam value_t VALUE_MAX    = '1;

  typedef struct packed {
    logic       top_changed;
    value_t     best_bid_price;
    value_t     best_bid_amount;
    logic       bid_valid;
    value_t     best_ask_price;
    value_t     best_ask_amount;
    logic       ask_valid;
    value_t     trade_price;
    value_t     trade_amount;
    logic [1:0] trade_side;
    logic       overflow;
  } book_snapshot_t;

  logic clk;
  logic rst_n;

  plb_in_if  in_ch ();
  plb_out_if out_ch ();

  price_level_order_book DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  value_t         level_px  [2][LEVELS];
  value_t         level_amt [2][LEVELS];
  int             level_cnt [2];
  value_t         last_trade_px;
  value_t         last_trade_amt;
  logic [1:0]     last_trade_side;
  book_snapshot_t due_snapshots[$];
  int             err_count;
  int             cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic value_t rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VALUE_BITS-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t pick_price(input value_t center);
    if ($urandom_range(0, 99) < 70) return center + value_t'($urandom_range(0, POOL_SPAN - 1));
    return rand_value();
  endfunction

  function automatic value_t pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 28) return VALUE_MAX;
    if (r < 60) return value_t'($urandom_range(1, 1000));
    return rand_value();
  endfunction

  function automatic logic apply_level(input int t, input value_t px, input value_t amt,
                                       output logic ovf);
    int   n;
    int   i;
    int   j;
    logic found;
    logic better;
    ovf = 1'b0;
    found = 1'b0;
    n = level_cnt[t];
    for (i = 0; i < n; i++) begin
      if (level_px[t][i] == px) begin
        found = 1'b1;
        break;
      end
      better = (t == BID_BOOK) ? (px > level_px[t][i]) : (px < level_px[t][i]);
      if (better) break;
    end
    if (found) begin
      if (amt == '0) begin
        for (j = i; j + 1 < n; j++) begin
          level_px[t][j]  = level_px[t][j+1];
          level_amt[t][j] = level_amt[t][j+1];
        end
        level_cnt[t] = n - 1;
      end else begin
        level_amt[t][i] = amt;
      end
      return i == 0;
    end
    if (amt == '0) return 1'b0;
    if (n == LEVELS) begin
      ovf = 1'b1;
      if (i >= LEVELS) return 1'b0;
      n = LEVELS - 1;
    end
    for (j = n; j > i; j--) begin
      level_px[t][j]  = level_px[t][j-1];
      level_amt[t][j] = level_amt[t][j-1];
    end
    level_px[t][i]  = px;
    level_amt[t][i] = amt;
    level_cnt[t] = n + 1;
    return i == 0;
  endfunction

  function automatic book_snapshot_t apply_request(input cmd_t c, input value_t px,
                                                   input value_t amt, input logic [1:0] sd);
    book_snapshot_t s;
    logic           top;
    logic           ovf;
    top = 1'b0;
    ovf = 1'b0;
    case (c)
      CMD_BID: top = apply_level(BID_BOOK, px, amt, ovf);
      CMD_ASK: top = apply_level(ASK_BOOK, px, amt, ovf);
      CMD_TRADE: begin
        last_trade_px   = px;
        last_trade_amt  = amt;
        last_trade_side = (sd == SIDE_BAD) ? SIDE_UNKNOWN : sd;
      end
      default: ;
    endcase
    s.top_changed     = top;
    s.bid_valid       = level_cnt[BID_BOOK] != 0;
    s.best_bid_price  = s.bid_valid ? level_px[BID_BOOK][0] : '0;
    s.best_bid_amount = s.bid_valid ? level_amt[BID_BOOK][0] : '0;
    s.ask_valid       = level_cnt[ASK_BOOK] != 0;
    s.best_ask_price  = s.ask_valid ? level_px[ASK_BOOK][0] : '0;
    s.best_ask_amount = s.ask_valid ? level_amt[ASK_BOOK][0] : '0;
    s.trade_price     = last_trade_px;
    s.trade_amount    = last_trade_amt;
    s.trade_side      = last_trade_side;
    s.overflow        = ovf;
    return s;
  endfunction

  task automatic send_request(input cmd_t c, input value_t px, input value_t amt,
                              input logic [1:0] sd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= c;
    in_ch.price  <= px;
    in_ch.amount <= amt;
    in_ch.side   <= sd;
    do @(posedge clk); while (!in_ch.ready);
    due_snapshots.push_back(apply_request(c, px, amt, sd));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_snapshots.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic test_level_edges();
    send_request(CMD_BID, VALUE_MAX, VALUE_MAX, SIDE_UNKNOWN);
    send_request(CMD_BID, '0, 48'd1, SIDE_BUY);
    send_request(CMD_BID, VALUE_MAX, 48'd5, SIDE_SELL);
    send_request(CMD_ASK, '0, '0, SIDE_BAD);
    send_request(CMD_ASK, '0, VALUE_MAX, SIDE_UNKNOWN);
    send_request(CMD_ASK, VALUE_MAX, 48'd1, SIDE_UNKNOWN);
    send_request(CMD_ASK, '0, '0, SIDE_UNKNOWN);
    send_request(CMD_BID, VALUE_MAX, '0, SIDE_UNKNOWN);
    send_request(CMD_BID, '0, '0, SIDE_UNKNOWN);
    send_request(CMD_ASK, VALUE_MAX, '0, SIDE_UNKNOWN);
    send_request(CMD_BID, 48'd5, '0, SIDE_UNKNOWN);
    send_request(CMD_NONE, rand_value(), rand_value(), 2'($urandom));
  endtask

  task automatic test_trade_record();
    send_request(CMD_TRADE, VALUE_MAX, VALUE_MAX, SIDE_SELL);
    send_request(CMD_TRADE, '0, '0, SIDE_BUY);
    send_request(CMD_TRADE, rand_value(), rand_value(), SIDE_BAD);
    send_request(CMD_TRADE, rand_value(), rand_value(), SIDE_UNKNOWN);
    send_request(CMD_NONE, VALUE_MAX, VALUE_MAX, SIDE_BAD);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < LEVELS; k++)
      send_request(CMD_BID, value_t'(1000 + ((k * 37) % LEVELS) * 4), rand_value() | 48'd1,
                   SIDE_UNKNOWN);
    send_request(CMD_BID, 48'd2000, rand_value() | 48'd1, SIDE_UNKNOWN);
    send_request(CMD_BID, 48'd10, rand_value() | 48'd1, SIDE_UNKNOWN);
    send_request(CMD_BID, 48'd1004, 48'd77, SIDE_UNKNOWN);
    send_request(CMD_BID, 48'd2000, '0, SIDE_UNKNOWN);
    for (int k = 0; k < LEVELS; k++)
      send_request(CMD_ASK, value_t'(1000 + ((k * 29) % LEVELS) * 4), rand_value() | 48'd1,
                   SIDE_UNKNOWN);
    send_request(CMD_ASK, 48'd500, rand_value() | 48'd1, SIDE_UNKNOWN);
    send_request(CMD_ASK, 48'd5000, rand_value() | 48'd1, SIDE_UNKNOWN);
    send_request(CMD_ASK, 48'd1248, 48'd99, SIDE_UNKNOWN);
    send_request(CMD_ASK, 48'd500, '0, SIDE_UNKNOWN);
  endtask

  task automatic test_random_book(input value_t center, input int count);
    int   r;
    cmd_t c;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = CMD_BID;
      else if (r < 80) c = CMD_ASK;
      else if (r < 95) c = CMD_TRADE;
      else c = CMD_NONE;
      send_request(c, pick_price(center), pick_amount(), 2'($urandom));
      if (k % 300 == 299) drain_results();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_BID;
    in_ch.price  <= '0;
    in_ch.amount <= '0;
    in_ch.side   <= SIDE_UNKNOWN;
    level_cnt[BID_BOOK] = 0;
    level_cnt[ASK_BOOK] = 0;
    last_trade_px   = '0;
    last_trade_amt  = '0;
    last_trade_side = SIDE_UNKNOWN;
    err_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_level_edges();
    test_trade_record();
    test_full_table();
    test_random_book('0, 425);
    test_random_book(VALUE_MAX - POOL_SPAN + 1, 425);
    test_random_book(rand_value() >> 1, 425);
    test_random_book(rand_value() >> 1, 425);
    drain_results();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  function automatic int ready_run();
    if ($urandom_range(0, 99) < 30) return $urandom_range(100, 400);
    return $urandom_range(1, 12);
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    repeat (9) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (ready_run()) @(posedge clk);
      out_ch.ready <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    book_snapshot_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_snapshots.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result, bid %h ask %h", $time,
                 out_ch.best_bid_price, out_ch.best_ask_price);
      end else begin
        want = due_snapshots.pop_front();
        check_field("top_changed", 64'(want.top_changed), 64'(out_ch.top_changed));
        check_field("best_bid_price", 64'(want.best_bid_price), 64'(out_ch.best_bid_price));
        check_field("best_bid_amount", 64'(want.best_bid_amount),
                    64'(out_ch.best_bid_amount));
        check_field("bid_valid", 64'(want.bid_valid), 64'(out_ch.bid_valid));
        check_field("best_ask_price", 64'(want.best_ask_price), 64'(out_ch.best_ask_price));
        check_field("best_ask_amount", 64'(want.best_ask_amount),
                    64'(out_ch.best_ask_amount));
        check_field("ask_valid", 64'(want.ask_valid), 64'(out_ch.ask_valid));
        check_field("trade_price", 64'(want.trade_price), 64'(out_ch.trade_price));
        check_field("trade_amount", 64'(want.trade_amount), 64'(out_ch.trade_amount));
        check_field("trade_side", 64'(want.trade_side), 64'(out_ch.trade_side));
        check_field("overflow", 64'(want.overflow), 64'(out_ch.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, due_snapshots.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
